// ----- rtl/rtdc_pkg.sv -----
// ============================================================================
// rtdc_pkg
// Shared types, fixed-point constants and stage counts of the RTD converter.
// ============================================================================
package rtdc_pkg;

    // Sideband that follows an item down the pipeline.
    typedef struct packed {
        logic quad;  // quadratic branch gives the result
        logic ovf;   // polynomial ratio beyond the clamp point
    } t_tag;

    // Long divider: quotient bits, one per stage.
    localparam int QUO_W      = 63;
    // Square root: one result bit per stage.
    localparam int SQRT_STEPS = 32;
    localparam int SQ_W       = 64;
    localparam int S_W        = 33;

    // Rounding divide by 5775 of the quadratic result.
    // Dividend is clamped at 5775 * 2^18 (already past the output range),
    // then floor(x / 5775) = (x * CDIV_RECIP) >> 43 exactly below that.
    localparam int CDIV_Q_W   = 19;
    localparam int CDIV_X_W   = 31;
    localparam int CDIV_P_W   = 62;
    localparam int CDIV_SHIFT = 43;
    localparam logic [CDIV_X_W-1:0] CDIV_X_MAX = 31'd1513881600;  // 5775 << 18
    localparam logic [CDIV_X_W-1:0] CDIV_RECIP = 31'd1523132991;  // ceil(2^43/5775)
    localparam logic [31:0] CVD_A_Q16  = 32'd2561343488;  // 39083 << 16
    localparam logic [17:0] CVD_RND    = 18'd184800;      // 5775 * 32
    localparam logic [6:0]  CVD_SCALE  = 7'd125;

    // Quadratic radicand terms.
    localparam logic [30:0] CVD_A_SQ = 31'd1527480889;
    localparam logic [27:0] CVD_4B   = 28'd231000000;

    // Polynomial branch.
    localparam int Y_W   = 26;
    localparam int G_W   = 38;
    localparam int G_LO  = 19;
    localparam int T_W   = 26;
    localparam logic [Y_W-1:0] Y_MAX   = 26'd33554432;    // 512.0 in Q16
    localparam logic [G_W-1:0] POLY_A5 = 38'd179957580746;
    localparam logic [G_W-1:0] POLY_ADD [4] = '{
        38'd32492786764, 38'd10867185901, 38'd11372908473, 38'd9546853906
    };
    localparam int POLY_SHIFT [4] = '{26, 25, 25, 26};
    localparam logic signed [T_W-1:0] POLY_A0 = -26'sd61957;

    // Output range.
    localparam logic signed [T_W-1:0] OUT_MAX = 26'sd262143;
    localparam logic signed [T_W-1:0] OUT_MIN = -26'sd262144;

    // Stage counts.
    localparam int FRONT_LAT = 3;
    localparam int DIV_LAT   = QUO_W;
    localparam int SQRT_LAT  = SQRT_STEPS;
    localparam int CDIV_LAT  = 2;
    localparam int POLY_LAT  = 11;
    localparam int POLY_PAD  = SQRT_LAT + CDIV_LAT - POLY_LAT;
    localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT + SQRT_LAT + CDIV_LAT + 1;

endpackage

// ----- rtl/rtd_code_to_temperature_top.sv -----
// ============================================================================
// rtd_code_to_temperature_top
// Platinum RTD converter code to temperature in 1/256 degree C.
// ============================================================================
//
// Channel     Direction  Handshake                 Payload
// ---------   ---------  ------------------------  ---------------------------
// config      in/out     psel/penable/pwrite       paddr, pwdata, prdata
// code in     in         start, busy               i_rtd_code
// result      out        o_result_valid strobe     o_temperature_q8,
//                                                  o_used_polynomial,
//                                                  o_saturated
//
// One transaction accepted per cycle; busy is always low.
// An accepted code passes the front stages, the 63-stage long divider,
// the 32-stage square root, the constant divider and the output register.
// Synchronous active-low reset clears all valid bits and loads the register
// defaults (100 ohm nominal, 430 ohm reference).
// Results are shown for one cycle only; the receiver cannot stall.
//
module rtd_code_to_temperature_top #(
    parameter int CODE_BITS = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // code input
    input  logic                  start,
    input  logic [CODE_BITS-1:0]  i_rtd_code,
    output logic                  busy,
    // result
    output logic                  o_result_valid,
    output logic signed [18:0]    o_temperature_q8,
    output logic                  o_used_polynomial,
    output logic                  o_saturated
);
    localparam int DW = CODE_BITS + 14;   // base term d = R0 << CODE_BITS
    localparam int NW = CODE_BITS + 16;   // n = code * Rref
    localparam int QW = NW + 28;          // 4b-scaled excess
    localparam int PW = DW + 31;          // a^2 * d
    localparam int HW = NW + 7;           // 100 * n
    localparam int TW = rtdc_pkg::T_W;

    localparam logic REG_NOMINAL   = 1'b0;
    localparam logic REG_REFERENCE = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [13:0] r_nominal;
    logic [15:0] r_reference;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal   <= 14'd100;
            r_reference <= 16'd430;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_NOMINAL:   r_nominal   <= pwdata[13:0];
                REG_REFERENCE: r_reference <= pwdata[15:0];
                default:       r_nominal   <= r_nominal;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_NOMINAL:   prdata = {18'd0, r_nominal};
            REG_REFERENCE: prdata = {16'd0, r_reference};
            default:       prdata = '0;
        endcase
    end

    // Registers must only change while the pipe is empty: the user ensures it,
    // not the block. Every stage reads the live value of the base term.
    logic [13:0]   w_r0;
    logic [DW-1:0] w_d;

    assign w_r0 = (r_nominal == 14'd0) ? 14'd1 : r_nominal;
    assign w_d  = {w_r0, {CODE_BITS{1'b0}}};

    // ------------------------------------------------------------------
    // Front stages
    // ------------------------------------------------------------------
    logic w_accept;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // stage 1: n = code * Rref
    logic          r_s1_valid;
    logic [NW-1:0] r_s1_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_n <= NW'(i_rtd_code) * NW'(r_reference);
    end

    // stage 2: radicand terms and scaled ratio
    logic          r_s2_valid;
    logic          r_s2_gt;
    logic [QW-1:0] r_s2_q;
    logic [PW-1:0] r_s2_p;
    logic [HW-1:0] r_s2_n100;
    logic [NW-1:0] w_nd;

    assign w_nd = r_s1_n - NW'(w_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_gt   <= r_s1_n > NW'(w_d);
        r_s2_q    <= QW'(rtdc_pkg::CVD_4B) * QW'(w_nd);
        r_s2_p    <= PW'(rtdc_pkg::CVD_A_SQ) * PW'(w_d);
        r_s2_n100 <= HW'(r_s1_n) * HW'(7'd100);
    end

    // stage 3: branch choice and divider operands
    //   quadratic: dividend (a^2 d - 4b(n-d)) * 2^32
    //   polynomial: dividend 100 n * 2^53, quotient >> 37 is y in Q16
    logic           r_s3_valid;
    rtdc_pkg::t_tag r_s3_tag;
    logic [DW-1:0]  r_s3_rem;
    logic [rtdc_pkg::QUO_W-1:0] r_s3_tail;
    logic           w_quad;
    logic           w_ovf;
    logic [PW-1:0]  w_num;
    logic [DW-1:0]  w_hi100;

    assign w_quad  = r_s2_gt && (PW'(r_s2_q) <= r_s2_p);
    assign w_num   = r_s2_p - PW'(r_s2_q);
    assign w_hi100 = {1'b0, r_s2_n100[HW-1:10]};
    assign w_ovf   = w_hi100 >= w_d;   // ratio far above clamp point

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_tag.quad <= w_quad;
        r_s3_tag.ovf  <= w_ovf;
        if (w_quad) begin
            r_s3_rem  <= w_num[PW-1:31];
            r_s3_tail <= {w_num[30:0], 32'd0};
        end else if (w_ovf) begin
            r_s3_rem  <= '0;
            r_s3_tail <= '0;
        end else begin
            r_s3_rem  <= w_hi100;
            r_s3_tail <= {r_s2_n100[9:0], 53'd0};
        end
    end

    // ------------------------------------------------------------------
    // Divider, then quadratic and polynomial lanes side by side
    // ------------------------------------------------------------------
    logic                       w_div_valid;
    rtdc_pkg::t_tag             w_div_tag;
    logic [rtdc_pkg::QUO_W-1:0] w_div_quo;

    rtdc_div #(
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_valid),
        .i_tag   (r_s3_tag),
        .i_rem   (r_s3_rem),
        .i_tail  (r_s3_tail),
        .i_d     (w_d),
        .o_valid (w_div_valid),
        .o_tag   (w_div_tag),
        .o_quo   (w_div_quo)
    );

    logic                     w_sq_valid;
    rtdc_pkg::t_tag           w_sq_tag;
    logic [rtdc_pkg::S_W-1:0] w_sq_root;

    rtdc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .i_tag   (w_div_tag),
        .i_rad   (w_div_quo),
        .o_valid (w_sq_valid),
        .o_tag   (w_sq_tag),
        .o_root  (w_sq_root)
    );

    logic                          w_cd_valid;
    rtdc_pkg::t_tag                w_cd_tag;
    logic [rtdc_pkg::CDIV_Q_W-1:0] w_cd_quo;

    rtdc_cdiv u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .i_tag   (w_sq_tag),
        .i_root  (w_sq_root),
        .o_valid (w_cd_valid),
        .o_tag   (w_cd_tag),
        .o_quo   (w_cd_quo)
    );

    logic signed [TW-1:0] w_poly_t;

    rtdc_poly u_poly (
        .i_clk  (i_clk),
        .i_quo  (w_div_quo),
        .i_ovf  (w_div_tag.ovf),
        .o_temp (w_poly_t)
    );

    // ------------------------------------------------------------------
    // Branch select, saturation, output register
    // ------------------------------------------------------------------
    logic signed [TW-1:0] w_t;
    logic signed [18:0]   n_temp;
    logic                 n_sat;

    assign w_t = w_cd_tag.quad ? $signed({{(TW - rtdc_pkg::CDIV_Q_W){1'b0}}, w_cd_quo})
                               : w_poly_t;

    always_comb begin
        if (w_t > rtdc_pkg::OUT_MAX) begin
            n_temp = rtdc_pkg::OUT_MAX[18:0];
            n_sat  = 1'b1;
        end else if (w_t < rtdc_pkg::OUT_MIN) begin
            n_temp = rtdc_pkg::OUT_MIN[18:0];
            n_sat  = 1'b1;
        end else begin
            n_temp = w_t[18:0];
            n_sat  = 1'b0;
        end
    end

    logic               r_out_valid;
    logic signed [18:0] r_out_temp;
    logic               r_out_poly;
    logic               r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_cd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_temp <= n_temp;
        r_out_poly <= !w_cd_tag.quad;
        r_out_sat  <= n_sat;
    end

    assign o_result_valid    = r_out_valid;
    assign o_temperature_q8  = r_out_temp;
    assign o_used_polynomial = r_out_poly;
    assign o_saturated       = r_out_sat;

`ifndef SYNTHESIS
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##(rtdc_pkg::PIPE_LAT) o_result_valid)
        else $error("accepted code produced no result at fixed latency");

    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(w_accept, rtdc_pkg::PIPE_LAT))
        else $error("result strobe without matching accepted code");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_saturated) |->
            (o_temperature_q8 == 19'sh3FFFF || o_temperature_q8 == -19'sh40000))
        else $error("saturated result not at a range limit");

    a_quad_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_used_polynomial) |-> !o_temperature_q8[18])
        else $error("quadratic branch gave a negative temperature");
`endif

endmodule

// ----- rtl/rtdc_div.sv -----
// ============================================================================
// rtdc_div
// Pipelined restoring divider by the RTD base term, one quotient bit a stage.
// ============================================================================
module rtdc_div #(
    parameter int DW = 29
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  rtdc_pkg::t_tag            i_tag,
    input  logic [DW-1:0]             i_rem,
    input  logic [rtdc_pkg::QUO_W-1:0] i_tail,
    input  logic [DW-1:0]             i_d,
    output logic                      o_valid,
    output rtdc_pkg::t_tag            o_tag,
    output logic [rtdc_pkg::QUO_W-1:0] o_quo
);
    localparam int QW = rtdc_pkg::QUO_W;

    logic                 r_valid [QW];
    rtdc_pkg::t_tag       r_tag   [QW];
    logic [DW-1:0]        r_rem   [QW];
    logic [QW-1:0]        r_lq    [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic           v_in;
        rtdc_pkg::t_tag tag_in;
        logic [DW-1:0]  rem_in;
        logic [QW-1:0]  lq_in;
        logic [DW:0]    w_t;
        logic           w_ge;
        logic [DW-1:0]  n_rem;
        logic [QW-1:0]  n_lq;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign tag_in = i_tag;
            assign rem_in = i_rem;
            assign lq_in  = i_tail;
        end else begin : g_next
            assign v_in   = r_valid[k-1];
            assign tag_in = r_tag[k-1];
            assign rem_in = r_rem[k-1];
            assign lq_in  = r_lq[k-1];
        end

        // shift in next dividend bit, subtract if it fits
        assign w_t  = {rem_in, lq_in[QW-1]};
        assign w_ge = w_t >= {1'b0, i_d};

        always_comb begin
            if (w_ge) begin
                n_rem = DW'(w_t - {1'b0, i_d});
            end else begin
                n_rem = w_t[DW-1:0];
            end
            n_lq = {lq_in[QW-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[k] <= tag_in;
            r_rem[k] <= n_rem;
            r_lq[k]  <= n_lq;
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_tag   = r_tag[QW-1];
    assign o_quo   = r_lq[QW-1];

endmodule

// ----- rtl/rtdc_sqrt.sv -----
// ============================================================================
// rtdc_sqrt
// Pipelined floor square root of the Q32 radicand, one result bit a stage.
// ============================================================================
module rtdc_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  rtdc_pkg::t_tag             i_tag,
    input  logic [rtdc_pkg::QUO_W-1:0] i_rad,
    output logic                       o_valid,
    output rtdc_pkg::t_tag             o_tag,
    output logic [rtdc_pkg::S_W-1:0]   o_root
);
    localparam int NS = rtdc_pkg::SQRT_STEPS;
    localparam int W  = rtdc_pkg::SQ_W;

    logic           r_valid [NS];
    rtdc_pkg::t_tag r_tag   [NS];
    logic [W-1:0]   r_v     [NS];
    logic [W-1:0]   r_res   [NS];

    for (genvar k = 0; k < NS; k++) begin : g_step
        localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
        logic           v_in;
        rtdc_pkg::t_tag tag_in;
        logic [W-1:0]   val_in;
        logic [W-1:0]   res_in;
        logic [W-1:0]   w_sum;
        logic [W-1:0]   n_v;
        logic [W-1:0]   n_res;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign tag_in = i_tag;
            assign val_in = {1'b0, i_rad};
            assign res_in = '0;
        end else begin : g_next
            assign v_in   = r_valid[k-1];
            assign tag_in = r_tag[k-1];
            assign val_in = r_v[k-1];
            assign res_in = r_res[k-1];
        end

        assign w_sum = res_in + BIT;

        always_comb begin
            if (val_in >= w_sum) begin
                n_v   = val_in - w_sum;
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_v   = val_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[k] <= tag_in;
            r_v[k]   <= n_v;
            r_res[k] <= n_res;
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_tag   = r_tag[NS-1];
    assign o_root  = r_res[NS-1][rtdc_pkg::S_W-1:0];

endmodule

// ----- rtl/rtdc_cdiv.sv -----
// ============================================================================
// rtdc_cdiv
// Quadratic result scaling: (A*2^16 - s) * 128000 / (5775*2^16), rounded.
// ============================================================================
module rtdc_cdiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  rtdc_pkg::t_tag                i_tag,
    input  logic [rtdc_pkg::S_W-1:0]      i_root,
    output logic                          o_valid,
    output rtdc_pkg::t_tag                o_tag,
    output logic [rtdc_pkg::CDIV_Q_W-1:0] o_quo
);
    localparam int XW = rtdc_pkg::CDIV_X_W;
    localparam int PW = rtdc_pkg::CDIV_P_W;

    logic [31:0]    w_diff;
    logic [38:0]    w_x;
    logic [XW-1:0]  w_xc;
    logic           r0_valid;
    rtdc_pkg::t_tag r0_tag;
    logic [XW-1:0]  r0_x;
    logic [PW-1:0]  w_prod;
    logic           r1_valid;
    rtdc_pkg::t_tag r1_tag;
    logic [rtdc_pkg::CDIV_Q_W-1:0] r1_quo;

    // scale by 125 with half-divisor offset, drop 6 bits: divisor is then 5775
    assign w_diff = rtdc_pkg::CVD_A_Q16 - i_root[31:0];
    assign w_x    = 39'(w_diff) * 39'(rtdc_pkg::CVD_SCALE) + 39'(rtdc_pkg::CVD_RND);

    // anything at or above the clamp already saturates the output
    assign w_xc = (w_x[38:6] >= 33'(rtdc_pkg::CDIV_X_MAX)) ? rtdc_pkg::CDIV_X_MAX
                                                           : w_x[36:6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_tag <= i_tag;
        r0_x   <= w_xc;
    end

    // reciprocal multiply, exact over the clamped range
    assign w_prod = PW'(r0_x) * PW'(rtdc_pkg::CDIV_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_tag <= r0_tag;
        r1_quo <= w_prod[PW-1:rtdc_pkg::CDIV_SHIFT];
    end

    assign o_valid = r1_valid;
    assign o_tag   = r1_tag;
    assign o_quo   = r1_quo;

endmodule

// ----- rtl/rtdc_poly.sv -----
// ============================================================================
// rtdc_poly
// Fifth-degree polynomial lane, Horner form with split multiplies, plus
// delay to line up with the quadratic lane.
// ============================================================================
module rtdc_poly (
    input  logic                              i_clk,
    input  logic [rtdc_pkg::QUO_W-1:0]        i_quo,
    input  logic                              i_ovf,
    output logic signed [rtdc_pkg::T_W-1:0]   o_temp
);
    localparam int YW = rtdc_pkg::Y_W;
    localparam int GW = rtdc_pkg::G_W;
    localparam int GL = rtdc_pkg::G_LO;
    localparam int PW = GW - GL + YW;
    localparam int TW = rtdc_pkg::T_W;
    localparam int ND = rtdc_pkg::POLY_PAD;

    logic [YW-1:0]        w_y;
    logic [YW-1:0]        r_y;
    logic [PW-1:0]        r_ph [5];
    logic [PW-1:0]        r_pl [5];
    logic [YW-1:0]        r_ya [5];
    logic [YW-1:0]        r_yb [4];
    logic [GW-1:0]        r_g  [4];
    logic signed [TW-1:0] r_t;
    logic signed [TW-1:0] r_dly [ND];

    // ratio in Q16, clamped at 512.0
    always_comb begin
        w_y = i_quo[rtdc_pkg::QUO_W-1:rtdc_pkg::QUO_W-YW];
        if (i_ovf || (w_y > rtdc_pkg::Y_MAX)) begin
            w_y = rtdc_pkg::Y_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y <= w_y;
    end

    for (genvar i = 0; i < 5; i++) begin : g_horner
        logic [GW-1:0] g_in;
        logic [YW-1:0] y_in;
        logic [63:0]   w_prod;

        if (i == 0) begin : g_first
            assign g_in = rtdc_pkg::POLY_A5;
            assign y_in = r_y;
        end else begin : g_next
            assign g_in = r_g[i-1];
            assign y_in = r_yb[i-1];
        end

        // partial products
        always_ff @(posedge i_clk) begin
            r_ph[i] <= PW'(g_in[GW-1:GL]) * PW'(y_in);
            r_pl[i] <= PW'(g_in[GL-1:0]) * PW'(y_in);
            r_ya[i] <= y_in;
        end

        assign w_prod = {r_ph[i], {GL{1'b0}}} + 64'(r_pl[i]);

        if (i < 4) begin : g_acc
            always_ff @(posedge i_clk) begin
                r_g[i]  <= rtdc_pkg::POLY_ADD[i] + GW'(w_prod >> rtdc_pkg::POLY_SHIFT[i]);
                r_yb[i] <= r_ya[i];
            end
        end else begin : g_last
            logic [64:0] w_rnd;
            assign w_rnd = {1'b0, w_prod} + (65'd1 << 39);
            always_ff @(posedge i_clk) begin
                r_t <= $signed({1'b0, w_rnd[64:40]}) + rtdc_pkg::POLY_A0;
            end
        end
    end

    for (genvar k = 0; k < ND; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (k == 0) begin
                r_dly[k] <= r_t;
            end else begin
                r_dly[k] <= r_dly[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_temp = r_dly[ND-1];

endmodule

// ----- bench/rtd_temp_checker.sv -----
// ----------------------------------------------------------------------------
// rtd_temp_checker
// Watches the register port, the code input and the result strobe. It works
// out the expected temperature of each accepted code and compares every
// result in order.
// ----------------------------------------------------------------------------
module rtd_temp_checker #(
    parameter int CODE_BITS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    input  logic                 start,
    input  logic                 busy,
    input  logic [CODE_BITS-1:0] i_rtd_code,
    input  logic                 o_result_valid,
    input  logic signed [18:0]   o_temperature_q8,
    input  logic                 o_used_polynomial,
    input  logic                 o_saturated,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_poly_count,
    output int                   o_sat_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_NOMINAL   = 2'd0;
    localparam logic [1:0] REG_REFERENCE = 2'd1;

    typedef struct {
        logic signed [18:0] temp;
        logic               poly;
        logic               sat;
    } temp_result_t;

    temp_result_t expected_temps[$];
    logic [13:0]  nominal_ohms;
    logic [15:0]  reference_ohms;

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Code to temperature: quadratic above ratio one while its radicand is not negative, else the polynomial.
    function automatic temp_result_t rtd_temperature(logic [CODE_BITS-1:0] code);
        temp_result_t       r;
        logic [63:0]        r0, n, d, q, p, num, rad, s, y, g;
        logic signed [63:0] t;
        r0     = (nominal_ohms == 0) ? 64'd1 : 64'(nominal_ohms);
        n      = 64'(code) * 64'(reference_ohms);
        d      = r0 << CODE_BITS;
        r.poly = 1'b1;
        r.sat  = 1'b0;
        t      = 0;
        if (n > d) begin
            q = 64'd231000000 * (n - d);
            p = 64'd1527480889 * d;
            if (q <= p) begin
                num    = p - q;
                rad    = ((num / d) << 32) + (((num % d) << 32) / d);
                s      = floor_sqrt(rad);
                t      = signed'(((((64'd39083 << 16) - s) * 64'd128000)
                         + 64'd189235200) / 64'd378470400);
                r.poly = 1'b0;
            end
        end
        if (r.poly) begin
            y = ((n * 64'd100) << 16) / d;
            if (y > (64'd512 << 16)) y = 64'd512 << 16;
            g = 64'd32492786764 + ((64'd179957580746 * y) >> 26);
            g = 64'd10867185901 + ((g * y) >> 25);
            g = 64'd11372908473 + ((g * y) >> 25);
            g = 64'd9546853906 + ((g * y) >> 26);
            t = -64'sd61957 + signed'((g * y + (64'd1 << 39)) >> 40);
        end
        if (t > 64'sd262143) begin
            t     = 64'sd262143;
            r.sat = 1'b1;
        end else if (t < -64'sd262144) begin
            t     = -64'sd262144;
            r.sat = 1'b1;
        end
        r.temp = t[18:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (o_fail_count < 30)
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    assign o_pending = expected_temps.size();

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        o_poly_count = 0;
        o_sat_count  = 0;
    end

    always @(posedge i_clk) begin
        temp_result_t want;
        if (!i_rst_n) begin
            nominal_ohms   <= 14'd100;
            reference_ohms <= 16'd430;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[2:2])
                    REG_NOMINAL[0:0]:   nominal_ohms   <= pwdata[13:0];
                    REG_REFERENCE[0:0]: reference_ohms <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_temps.push_back(rtd_temperature(i_rtd_code));
            if (o_result_valid) begin
                if (expected_temps.size() == 0) begin
                    report_mismatch("unexpected result", o_temperature_q8, 0);
                end else begin
                    want = expected_temps.pop_front();
                    o_checked++;
                    if (want.poly) o_poly_count++;
                    if (want.sat)  o_sat_count++;
                    if (o_temperature_q8 !== want.temp)
                        report_mismatch("temperature_q8", o_temperature_q8, want.temp);
                    if (o_used_polynomial !== want.poly)
                        report_mismatch("used_polynomial", o_used_polynomial, want.poly);
                    if (o_saturated !== want.sat)
                        report_mismatch("saturated", o_saturated, want.sat);
                end
            end
        end
    end
endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Top of the RTD converter bench: drives register settings and codes with
// varied sender gaps, while the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_BITS   = 15;
    localparam int IDLE_LIMIT  = 5000;          // cycles without any transaction
    localparam int DRAIN_WAIT  = rtdc_pkg::PIPE_LAT + 16;
    localparam logic [2:0] ADDR_NOMINAL   = 3'd0;
    localparam logic [2:0] ADDR_REFERENCE = 3'd4;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  start = 1'b0;
    logic [CODE_BITS-1:0]  i_rtd_code = '0;
    logic                  busy;
    logic                  o_result_valid;
    logic signed [18:0]    o_temperature_q8;
    logic                  o_used_polynomial;
    logic                  o_saturated;

    int fail_count, pending, checked, poly_count, sat_count;
    int idle_pct;        // percent of cycles the sender holds off
    int sent_codes;
    int quiet_cycles;

    always #5 i_clk = ~i_clk;

    rtd_code_to_temperature_top #(.CODE_BITS(CODE_BITS)) dut (.*);

    rtd_temp_checker #(.CODE_BITS(CODE_BITS)) u_checker (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .start, .busy, .i_rtd_code, .o_result_valid, .o_temperature_q8,
        .o_used_polynomial, .o_saturated,
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked),
        .o_poly_count(poly_count), .o_sat_count(sat_count)
    );

    // Watchdog: any accepted code or result strobe counts as progress.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Register write with a setup and an access phase; called and returning at a falling edge.
    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One code transaction with a random number of gap cycles ahead of it.
    task automatic send_code(logic [CODE_BITS-1:0] code);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_rtd_code <= code;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        sent_codes++;
    endtask

    // Let every outstanding result arrive before touching the registers.
    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // Code that lands right at ratio one for the given registers.
    function automatic logic [CODE_BITS-1:0] unity_code(int nom, int refr);
        longint c;
        if (refr == 0) return '0;
        c = (longint'(nom == 0 ? 1 : nom) << CODE_BITS) / refr;
        return (c > 32767) ? 15'h7FFF : CODE_BITS'(c);
    endfunction

    initial begin
        int noms  [8] = '{100, 1000, 1, 10000, 0, 16383, 200, 500};
        int refs  [8] = '{430, 4300, 65535, 1, 430, 65535, 0, 1234};
        int pcts  [4] = '{0, 62, 0, 33};
        int dir_codes [8] = '{0, 1, 2, 16384, 21845, 32767, 8000, 10000};
        logic [CODE_BITS-1:0] edge_code;
        int pick;

        sent_codes = 0;
        idle_pct   = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed codes on the reset settings: extremes and the ratio-one edge.
        edge_code = unity_code(100, 430);
        foreach (dir_codes[k])
            send_code(CODE_BITS'(dir_codes[k]));
        for (int k = -2; k <= 2; k++) send_code(edge_code + CODE_BITS'(k));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            // Upper bits of the data word must be dropped by the registers.
            reg_write(ADDR_NOMINAL,   32'(noms[ph]) | (ph[0] ? 32'hFFFF_C000 : 32'h0));
            reg_write(ADDR_REFERENCE, 32'(refs[ph]) | (ph[1] ? 32'hFFFF_0000 : 32'h0));
            idle_pct  = pcts[ph % 4];
            edge_code = unity_code(noms[ph], refs[ph]);
            send_code('0);
            send_code('1);
            send_code(edge_code);
            send_code(edge_code + 1'b1);
            for (int i = 0; i < 250; i++) begin
                pick = $urandom_range(9);
                if (pick < 6)
                    send_code(CODE_BITS'($urandom));
                else if (pick < 9)
                    send_code(edge_code + CODE_BITS'($urandom_range(64)) - 15'd32);
                else
                    send_code(CODE_BITS'($urandom_range(31)));
                // runs of back-to-back codes inside the gapped phases
                if (i % 60 == 30) idle_pct = 0;
                if (i % 60 == 45) idle_pct = pcts[ph % 4];
            end
            drain();
        end

        $display("codes sent %0d, results checked %0d over 8 register settings",
                 sent_codes, checked);
        $display("polynomial branch %0d, saturated %0d", poly_count, sat_count);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
